@@ sv/mwdt_pkg.sv @@
// Package for the multiwave / dual-tone keypad generator.
// Holds widths, the config struct, the quarter-wave sine ROM and the key decode.
// No dependencies.
`timescale 1ns / 1ps

package mwdt_pkg;

  localparam int PHASE_BITS    = 32;
  localparam int SINE_DEPTH    = 256;
  localparam int ROM_IDX_BITS  = $clog2(SINE_DEPTH);
  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 24;
  localparam int MODE_BITS     = 3;
  localparam int KEY_BITS      = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic [COUNT_BITS-1:0]         count_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MODE_BITS-1:0]          mode_t;
  typedef logic [KEY_BITS-1:0]           key_t;

  typedef enum logic [MODE_BITS-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SAW      = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_KEYPAD   = 3'd4
  } wave_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WAVE_MODE   = 2'd0,
    REG_PHASE_STEP  = 2'd1,
    REG_TONE_LENGTH = 2'd2,
    REG_KEYPAD_KEY  = 2'd3
  } cfg_reg_e;

  localparam key_t KEY_RESET = 8'h30;

  typedef struct packed {
    mode_t  wave_mode;
    phase_t phase_step;
    count_t tone_length;
    key_t   keypad_key;
  } cfg_t;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam longint unsigned Q30_ONE   = 64'd1 << 30;
  localparam longint unsigned PI_Q30    = (64'd314159265 << 30) / 64'd100000000;
  localparam longint unsigned SMAX_U    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam longint unsigned KEY_RATE  = 64'd8000;
  localparam longint unsigned KEY_ROUND = KEY_RATE / 64'd2;

  // Fixed-point Taylor evaluation of sin(pi*(2k+1)/(4*depth)), Q30
  function automatic logic [SAMPLE_BITS-1:0] quarter_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    x  = (PI_Q30 * (64'd2 * longint'(k) + 64'd1)) >> (ROM_IDX_BITS + 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s * SMAX_U + (Q30_ONE >> 1)) >> 30;
    return r[SAMPLE_BITS-1:0];
  endfunction

  typedef logic [SINE_DEPTH-1:0][SAMPLE_BITS-1:0] sine_rom_t;

  function automatic sine_rom_t build_rom();
    sine_rom_t rom;
    for (int unsigned k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = quarter_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

  function automatic sample_t sine_at(phase_t p);
    logic [1:0]              quad;
    logic [ROM_IDX_BITS-1:0] idx;
    logic [SAMPLE_BITS-1:0]  v;
    quad = p[PHASE_BITS-1 -: 2];
    idx  = p[PHASE_BITS-3 -: ROM_IDX_BITS];
    if (quad[0]) begin
      idx = ~idx;
    end
    v = SINE_ROM[idx];
    return quad[1] ? sample_t'(-v) : sample_t'(v);
  endfunction

  // Keypad phase steps: round(f * 2^PHASE_BITS / 8000)
  localparam phase_t ROW_STEP [4] = '{
    phase_t'(((64'd697  << PHASE_BITS) + KEY_ROUND) / KEY_RATE),
    phase_t'(((64'd770  << PHASE_BITS) + KEY_ROUND) / KEY_RATE),
    phase_t'(((64'd852  << PHASE_BITS) + KEY_ROUND) / KEY_RATE),
    phase_t'(((64'd941  << PHASE_BITS) + KEY_ROUND) / KEY_RATE)
  };
  localparam phase_t COL_STEP [4] = '{
    phase_t'(((64'd1209 << PHASE_BITS) + KEY_ROUND) / KEY_RATE),
    phase_t'(((64'd1336 << PHASE_BITS) + KEY_ROUND) / KEY_RATE),
    phase_t'(((64'd1477 << PHASE_BITS) + KEY_ROUND) / KEY_RATE),
    phase_t'(((64'd1633 << PHASE_BITS) + KEY_ROUND) / KEY_RATE)
  };

  typedef struct packed {
    logic       valid;
    logic [1:0] row;
    logic [1:0] col;
  } key_sel_t;

  function automatic key_sel_t decode_key(key_t key);
    key_t     k;
    key_sel_t r;
    k = key;
    if (k >= 8'h41 && k <= 8'h44) begin
      k = k | 8'h20;
    end
    r = '0;
    case (k)
      8'h31: r = '{1'b1, 2'd0, 2'd0};
      8'h32: r = '{1'b1, 2'd0, 2'd1};
      8'h33: r = '{1'b1, 2'd0, 2'd2};
      8'h61: r = '{1'b1, 2'd0, 2'd3};
      8'h34: r = '{1'b1, 2'd1, 2'd0};
      8'h35: r = '{1'b1, 2'd1, 2'd1};
      8'h36: r = '{1'b1, 2'd1, 2'd2};
      8'h62: r = '{1'b1, 2'd1, 2'd3};
      8'h37: r = '{1'b1, 2'd2, 2'd0};
      8'h38: r = '{1'b1, 2'd2, 2'd1};
      8'h39: r = '{1'b1, 2'd2, 2'd2};
      8'h63: r = '{1'b1, 2'd2, 2'd3};
      8'h2a: r = '{1'b1, 2'd3, 2'd0};
      8'h30: r = '{1'b1, 2'd3, 2'd1};
      8'h23: r = '{1'b1, 2'd3, 2'd2};
      8'h64: r = '{1'b1, 2'd3, 2'd3};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/mwdt_if.sv @@
// Stream interfaces for the tone generator: tick requests in, samples out.
// Depends on mwdt_pkg.
`timescale 1ns / 1ps

interface mwdt_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mwdt_sample_if;
  logic                    valid;
  logic                    ready;
  mwdt_pkg::sample_t       sample;
  logic                    last;
  logic                    active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink   (input valid, input sample, input last, input active, output ready);
endinterface

@@ sv/mwdt_wave.sv @@
// Waveform unit: sample value and next phases from the current phases and config.
// Depends on mwdt_pkg (sine ROM, key decode, key steps).
`timescale 1ns / 1ps

module mwdt_wave (
  input  mwdt_pkg::cfg_t    cfg_i,
  input  mwdt_pkg::phase_t  main_phase_i,
  input  mwdt_pkg::phase_t  second_phase_i,
  output mwdt_pkg::sample_t sample_o,
  output mwdt_pkg::phase_t  main_phase_o,
  output mwdt_pkg::phase_t  second_phase_o
);
  import mwdt_pkg::*;

  key_sel_t                 key_sel;
  sample_t                  sine_a;
  sample_t                  sine_b;
  logic signed [SAMPLE_BITS:0] key_sum;
  logic [SAMPLE_BITS-1:0]   tri_u;
  phase_t                   main_adv;

  assign key_sel  = decode_key(cfg_i.keypad_key);
  assign sine_a   = sine_at(main_phase_i);
  assign sine_b   = sine_at(second_phase_i);
  assign key_sum  = {sine_a[SAMPLE_BITS-1], sine_a} + {sine_b[SAMPLE_BITS-1], sine_b};
  assign tri_u    = main_phase_i[PHASE_BITS-2 -: SAMPLE_BITS];
  assign main_adv = main_phase_i + cfg_i.phase_step;

  always_comb begin
    sample_o       = '0;
    main_phase_o   = main_phase_i;
    second_phase_o = second_phase_i;
    case (cfg_i.wave_mode)
      WAVE_SINE: begin
        sample_o     = sine_a;
        main_phase_o = main_adv;
      end
      WAVE_SAW: begin
        sample_o     = sample_t'({~main_phase_i[PHASE_BITS-1],
                                  main_phase_i[PHASE_BITS-2 -: SAMPLE_BITS-1]});
        main_phase_o = main_adv;
      end
      WAVE_SQUARE: begin
        sample_o     = main_phase_i[PHASE_BITS-1] ? sample_t'(SAMPLE_MAX)
                                                  : sample_t'(SAMPLE_MIN);
        main_phase_o = main_adv;
      end
      WAVE_TRIANGLE: begin
        sample_o     = main_phase_i[PHASE_BITS-1] ? sample_t'(SAMPLE_MAX - tri_u)
                                                  : sample_t'(tri_u ^ SAMPLE_MIN);
        main_phase_o = main_adv;
      end
      WAVE_KEYPAD: begin
        if (key_sel.valid) begin
          sample_o       = key_sum[SAMPLE_BITS:1];
          main_phase_o   = main_phase_i + ROW_STEP[key_sel.row];
          second_phase_o = second_phase_i + COL_STEP[key_sel.col];
        end
      end
      default: begin
        sample_o = '0;
      end
    endcase
  end

endmodule

@@ sv/multiwave_and_dtmf_tone_generator_top.sv @@
// Top level of the multiwave / dual-tone keypad generator.
// Depends on mwdt_pkg, mwdt_if and mwdt_wave.
//
//   port       dir  handshake     contents
//   tick_i     in   valid/ready   restart
//   sample_o   out  valid/ready   sample (Q1.15), last, active
//   cfg_*_i    in   write enable  register index, write data
//
// One sample per clock: a tick request is taken each cycle the output register
// is empty or being drained, and its sample appears in the output register on
// the next edge. Phase add and ROM read are combinational. Reset clears the
// phases, the sample count and the output valid; config returns to defaults.
`timescale 1ns / 1ps

module multiwave_and_dtmf_tone_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mwdt_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [mwdt_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  mwdt_tick_if.sink                           tick_i,
  mwdt_sample_if.source                       sample_o
);
  import mwdt_pkg::*;

  cfg_t    cfg_q;
  phase_t  main_q, main_d, main_cur, main_nx;
  phase_t  second_q, second_d, second_cur, second_nx;
  count_t  cnt_q, cnt_d, cnt_cur;
  sample_t wave_smp;
  logic    accept, act, lst;
  logic    out_valid_q;
  sample_t smp_q;
  logic    last_q, active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_mode   <= WAVE_SINE;
      cfg_q.phase_step  <= '0;
      cfg_q.tone_length <= '0;
      cfg_q.keypad_key  <= KEY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WAVE_MODE:   cfg_q.wave_mode   <= cfg_data_i[MODE_BITS-1:0];
        REG_PHASE_STEP:  cfg_q.phase_step  <= cfg_data_i[PHASE_BITS-1:0];
        REG_TONE_LENGTH: cfg_q.tone_length <= cfg_data_i[COUNT_BITS-1:0];
        REG_KEYPAD_KEY:  cfg_q.keypad_key  <= cfg_data_i[KEY_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign tick_i.ready = !out_valid_q || sample_o.ready;
  assign accept       = tick_i.valid && tick_i.ready;

  assign main_cur   = tick_i.restart ? '0 : main_q;
  assign second_cur = tick_i.restart ? '0 : second_q;
  assign cnt_cur    = tick_i.restart ? '0 : cnt_q;
  assign act        = cnt_cur < cfg_q.tone_length;
  assign lst        = act && (cnt_cur == cfg_q.tone_length - count_t'(1));

  mwdt_wave u_wave (
    .cfg_i          (cfg_q),
    .main_phase_i   (main_cur),
    .second_phase_i (second_cur),
    .sample_o       (wave_smp),
    .main_phase_o   (main_nx),
    .second_phase_o (second_nx)
  );

  always_comb begin
    main_d   = main_q;
    second_d = second_q;
    cnt_d    = cnt_q;
    if (accept) begin
      main_d   = act ? main_nx : main_cur;
      second_d = act ? second_nx : second_cur;
      cnt_d    = act ? cnt_cur + count_t'(1) : cnt_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q      <= '0;
      second_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      main_q   <= main_d;
      second_q <= second_d;
      cnt_q    <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (sample_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q    <= act ? wave_smp : '0;
      last_q   <= lst;
      active_q <= act;
    end
  end

  assign sample_o.valid  = out_valid_q;
  assign sample_o.sample = smp_q;
  assign sample_o.last   = last_q;
  assign sample_o.active = active_q;

endmodule
